// ===== sv/assert_macros.svh =====
// Assertion macros shared by the PID bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication check.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mipid_pkg.sv =====
// Types, codes and reset gain table for the multichannel incremental PID bank.
`timescale 1ns / 1ps

package mipid_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 3;
    localparam int ERR_W   = 32;
    localparam int GSEL_W  = 2;
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_GAIN = 2'd2;

    // Gain select codes
    localparam logic [GSEL_W-1:0] GSEL_P = 2'd0;
    localparam logic [GSEL_W-1:0] GSEL_I = 2'd1;
    localparam logic [GSEL_W-1:0] GSEL_D = 2'd2;

    localparam int CHAN_CODES      = 1 << CHAN_W;
    localparam int PRESET_CHANNELS = 6;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [CHAN_W-1:0]       channel;
        logic signed [ERR_W-1:0] error_in;
        logic [GSEL_W-1:0]       gain_select;
        logic [GAIN_W-1:0]       gain_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_out;
        logic [CHAN_W-1:0]         channel_out;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] p;
        logic [GAIN_W-1:0] i;
        logic [GAIN_W-1:0] d;
    } gain_set_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] e1;
        logic signed [ERR_W-1:0] e2;
    } err_hist_t;

    typedef struct packed {
        gain_set_t gains;
        err_hist_t hist;
    } loop_row_t;

    localparam int GSET_W     = $bits(gain_set_t);
    localparam int LOOP_ROW_W = $bits(loop_row_t);

    // Reset gains in hundredths, p, i, d per channel
    localparam int PRESET_HUNDREDTHS [PRESET_CHANNELS][3] = '{
        '{150, 0, 5}, '{65, 0, 10}, '{65, 0, 7},
        '{180, 0, 5}, '{85, 0, 10}, '{110, 0, 70}
    };

    // Build the reset gain sets for the first PRESET_CHANNELS channel codes, rounded half up; the rest stay zero.
    function automatic logic [CHAN_CODES*GSET_W-1:0] preset_gains(input int frac_bits);
        logic [CHAN_CODES*GSET_W-1:0] v;
        int                           g_val;
        v = '0;
        for (int c = 0; c < PRESET_CHANNELS; c++) begin
            for (int g = 0; g < 3; g++) begin
                g_val = ((PRESET_HUNDREDTHS[c][g] << frac_bits) + 50) / 100;
                v[c*GSET_W + (2-g)*GAIN_W +: GAIN_W] = GAIN_W'(g_val);
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/mipid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mipid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: old data on a same-address collision
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/multichannel_incremental_pid.sv =====
// Top level: bank of incremental PID loops with per-channel state in RAM.
// An accepted item passes through stage 1, stage 2, stage 3 and the output register before it appears on m_valid.
// Throughput: one item per cycle while the skid stage is empty; the loop-row RAM and
// the accumulator RAM each take one read and one write per cycle, with one-deep forwarding on each.
// Reset: synchronous, active low; live bits make the RAMs read as zero state and
// preset gains at once, so there is no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multichannel_incremental_pid #(
    parameter int CHANNELS       = 8,
    parameter int DATA_WIDTH     = 32,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mipid_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mipid_pkg::out_item_t  m_data
);

    import mipid_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COEF_W = GAIN_W + 3;
    localparam int PROD_W = COEF_W + ERR_W;
    localparam int TERM_W = PROD_W - GAIN_FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;
    localparam int ACC_W  = ((SUM_W > DATA_WIDTH) ? SUM_W : DATA_WIDTH) + 1;

    localparam logic [CHAN_CODES*GSET_W-1:0] PRESETS = preset_gains(GAIN_FRAC_BITS);

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        (ACC_W'(1) <<< (DATA_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

    // Pipeline advance and input handshake
    logic enable;
    logic accept;
    logic skid_valid_reg;

    assign enable  = !skid_valid_reg;
    assign s_ready = enable;
    assign accept  = s_valid && s_ready;

    // ---------------- Stage 1: loop row resolve and write back ----------------
    logic                 s1_valid_reg;
    in_item_t             s1_item_reg;
    logic [CHANNELS-1:0]  hist_live_reg;
    logic [CHANNELS-1:0]  gain_live_reg;

    logic [LOOP_ROW_W-1:0] ram_a_rd;
    loop_row_t             rd_row;
    logic [ADDR_W-1:0]     s1_addr;
    logic                  s1_in_range;
    logic                  fwd_a_hit;
    gain_set_t             s1_gains;
    err_hist_t             s1_hist;
    loop_row_t             s1_wr_row;
    logic                  a_we;
    logic                  s1_is_compute;
    logic                  s1_gain_ok;

    // Registered record of the last stage 1 write
    logic                  a_wrote_reg;
    logic [ADDR_W-1:0]     a_waddr_reg;
    loop_row_t             a_row_reg;

    assign rd_row        = loop_row_t'(ram_a_rd);
    assign s1_addr       = ADDR_W'(s1_item_reg.channel);
    assign s1_in_range   = int'(s1_item_reg.channel) < CHANNELS;
    assign fwd_a_hit     = a_wrote_reg && (a_waddr_reg == s1_addr);
    assign s1_is_compute = s1_item_reg.command == CMD_COMPUTE;

    mipid_ram #(
        .WIDTH (LOOP_ROW_W),
        .DEPTH (CHANNELS)
    ) u_loop_ram (
        .clk     (aclk),
        .wr_en   (a_we),
        .wr_addr (s1_addr),
        .wr_data (s1_wr_row),
        .rd_en   (enable),
        .rd_addr (ADDR_W'(s_data.channel)),
        .rd_data (ram_a_rd)
    );

    // Resolve gains and history: forward, stored, or reset value
    always_comb begin
        if (fwd_a_hit) begin
            s1_gains = a_row_reg.gains;
        end else if (gain_live_reg[s1_addr]) begin
            s1_gains = rd_row.gains;
        end else begin
            s1_gains = gain_set_t'(PRESETS[s1_item_reg.channel*GSET_W +: GSET_W]);
        end
        if (fwd_a_hit) begin
            s1_hist = a_row_reg.hist;
        end else if (hist_live_reg[s1_addr]) begin
            s1_hist = rd_row.hist;
        end else begin
            s1_hist = '0;
        end
    end

    // Build the row to write back
    always_comb begin
        s1_wr_row  = '{gains: s1_gains, hist: s1_hist};
        s1_gain_ok = 1'b0;
        if (s1_is_compute) begin
            s1_wr_row.hist.e1 = s1_item_reg.error_in;
            s1_wr_row.hist.e2 = s1_hist.e1;
        end else begin
            case (s1_item_reg.gain_select)
                GSEL_P: begin
                    s1_wr_row.gains.p = s1_item_reg.gain_value;
                    s1_gain_ok        = 1'b1;
                end
                GSEL_I: begin
                    s1_wr_row.gains.i = s1_item_reg.gain_value;
                    s1_gain_ok        = 1'b1;
                end
                GSEL_D: begin
                    s1_wr_row.gains.d = s1_item_reg.gain_value;
                    s1_gain_ok        = 1'b1;
                end
                default: begin
                    s1_gain_ok = 1'b0;
                end
            endcase
        end
    end

    assign a_we = enable && s1_valid_reg && s1_in_range &&
                  (s1_is_compute ||
                   ((s1_item_reg.command == CMD_WRITE_GAIN) && s1_gain_ok));

    // Form coefficients A = p + i + d, B = -(p + 2d), C = d
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;

    assign coef_a = COEF_W'(s1_gains.p) + COEF_W'(s1_gains.i) + COEF_W'(s1_gains.d);
    assign coef_b = COEF_W'(0) - (COEF_W'(s1_gains.p) + (COEF_W'(s1_gains.d) << 1));
    assign coef_c = COEF_W'(s1_gains.d);

    // Advance stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            a_wrote_reg   <= 1'b0;
            hist_live_reg <= '0;
            gain_live_reg <= '0;
        end else if (enable) begin
            s1_valid_reg <= accept;
            a_wrote_reg  <= a_we;
            if (s1_valid_reg && (s1_item_reg.command == CMD_CLEAR)) begin
                hist_live_reg <= '0;
            end else if (a_we) begin
                hist_live_reg[s1_addr] <= 1'b1;
                gain_live_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // ---------------- Stage 2: multiply ----------------
    logic                     s2_valid_reg;
    logic [CMD_W-1:0]         s2_cmd_reg;
    logic [CHAN_W-1:0]        s2_channel_reg;
    logic                     s2_in_range_reg;
    logic signed [COEF_W-1:0] s2_coef_a_reg;
    logic signed [COEF_W-1:0] s2_coef_b_reg;
    logic signed [COEF_W-1:0] s2_coef_c_reg;
    logic signed [ERR_W-1:0]  s2_err_reg;
    logic signed [ERR_W-1:0]  s2_e1_reg;
    logic signed [ERR_W-1:0]  s2_e2_reg;

    // Hold payload of stages 1 and 2
    always_ff @(posedge aclk) begin
        if (enable) begin
            s1_item_reg     <= s_data;
            a_waddr_reg     <= s1_addr;
            a_row_reg       <= s1_wr_row;
            s2_cmd_reg      <= s1_item_reg.command;
            s2_channel_reg  <= s1_item_reg.channel;
            s2_in_range_reg <= s1_in_range;
            s2_coef_a_reg   <= coef_a;
            s2_coef_b_reg   <= coef_b;
            s2_coef_c_reg   <= coef_c;
            s2_err_reg      <= s1_item_reg.error_in;
            s2_e1_reg       <= s1_hist.e1;
            s2_e2_reg       <= s1_hist.e2;
        end
    end

    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
    logic signed [PROD_W-1:0] prod_c;

    assign prod_a = PROD_W'(s2_coef_a_reg) * PROD_W'(s2_err_reg);
    assign prod_b = PROD_W'(s2_coef_b_reg) * PROD_W'(s2_e1_reg);
    assign prod_c = PROD_W'(s2_coef_c_reg) * PROD_W'(s2_e2_reg);

    // ---------------- Stage 3: accumulate, saturate, write back ----------------
    logic                     s3_valid_reg;
    logic [CMD_W-1:0]         s3_cmd_reg;
    logic [CHAN_W-1:0]        s3_channel_reg;
    logic                     s3_in_range_reg;
    logic signed [TERM_W-1:0] s3_term_a_reg;
    logic signed [TERM_W-1:0] s3_term_b_reg;
    logic signed [TERM_W-1:0] s3_term_c_reg;

    // Truncate products toward minus infinity and hold
    always_ff @(posedge aclk) begin
        if (enable) begin
            s3_cmd_reg      <= s2_cmd_reg;
            s3_channel_reg  <= s2_channel_reg;
            s3_in_range_reg <= s2_in_range_reg;
            s3_term_a_reg   <= TERM_W'(prod_a >>> GAIN_FRAC_BITS);
            s3_term_b_reg   <= TERM_W'(prod_b >>> GAIN_FRAC_BITS);
            s3_term_c_reg   <= TERM_W'(prod_c >>> GAIN_FRAC_BITS);
        end
    end

    logic [CHANNELS-1:0]          acc_live_reg;
    logic                         b_wrote_reg;
    logic [ADDR_W-1:0]            b_waddr_reg;
    logic signed [DATA_WIDTH-1:0] b_acc_reg;

    logic [DATA_WIDTH-1:0]        ram_b_rd;
    logic [ADDR_W-1:0]            s3_addr;
    logic                         fwd_b_hit;
    logic signed [DATA_WIDTH-1:0] acc_prev;
    logic signed [SUM_W-1:0]      delta;
    logic signed [ACC_W-1:0]      acc_sum;
    logic signed [ACC_W-1:0]      acc_sat;
    logic signed [DATA_WIDTH-1:0] acc_new;
    logic                         b_we;
    logic                         s3_is_compute;
    out_item_t                    s3_result;

    assign s3_addr       = ADDR_W'(s3_channel_reg);
    assign fwd_b_hit     = b_wrote_reg && (b_waddr_reg == s3_addr);
    assign s3_is_compute = s3_cmd_reg == CMD_COMPUTE;

    mipid_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CHANNELS)
    ) u_acc_ram (
        .clk     (aclk),
        .wr_en   (b_we),
        .wr_addr (s3_addr),
        .wr_data (acc_new),
        .rd_en   (enable),
        .rd_addr (ADDR_W'(s2_channel_reg)),
        .rd_data (ram_b_rd)
    );

    // Pick the current accumulator: forward, stored, or cleared
    always_comb begin
        if (fwd_b_hit) begin
            acc_prev = b_acc_reg;
        end else if (acc_live_reg[s3_addr]) begin
            acc_prev = ram_b_rd;
        end else begin
            acc_prev = '0;
        end
    end

    assign delta   = SUM_W'(s3_term_a_reg) + SUM_W'(s3_term_b_reg) + SUM_W'(s3_term_c_reg);
    assign acc_sum = ACC_W'(acc_prev) + ACC_W'(delta);

    // Saturate to the accumulator range
    always_comb begin
        if (acc_sum > ACC_MAX) begin
            acc_sat = ACC_MAX;
        end else if (acc_sum < ACC_MIN) begin
            acc_sat = ACC_MIN;
        end else begin
            acc_sat = acc_sum;
        end
    end

    assign acc_new = DATA_WIDTH'(acc_sat);
    assign b_we    = enable && s3_valid_reg && s3_is_compute && s3_in_range_reg;

    always_comb begin
        s3_result.channel_out = s3_channel_reg;
        if (s3_is_compute && s3_in_range_reg) begin
            s3_result.drive_out = DRIVE_W'(acc_new);
        end else begin
            s3_result.drive_out = '0;
        end
    end

    // Advance stage 2/3 control and accumulator live bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            b_wrote_reg  <= 1'b0;
            acc_live_reg <= '0;
        end else if (enable) begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            b_wrote_reg  <= b_we;
            if (s3_valid_reg && (s3_cmd_reg == CMD_CLEAR)) begin
                acc_live_reg <= '0;
            end else if (b_we) begin
                acc_live_reg[s3_addr] <= 1'b1;
            end
        end
    end

    // Hold the last accumulator write for forwarding
    always_ff @(posedge aclk) begin
        if (enable) begin
            b_waddr_reg <= s3_addr;
            b_acc_reg   <= acc_new;
        end
    end

    // ---------------- Output register with skid stage ----------------
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t skid_item_reg;
    logic      push;
    logic      pop;
    logic      out_load;
    logic      skid_load;

    assign push      = enable && s3_valid_reg;
    assign pop       = out_valid_reg && m_ready;
    assign out_load  = pop || !out_valid_reg;
    assign skid_load = push && !out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end else if (skid_load) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Move result items: skid drains first
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : s3_result;
        end
        if (skid_load) begin
            skid_item_reg <= s3_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // ---------------- Checks ----------------
    `ASSERT_IMPLIES(a_skid_behind_head, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPLIES(a_stall_only_on_result, aclk, aresetn, !s_ready, m_valid)
    `ASSERT_NEXT(a_clear_drops_history, aclk, aresetn, enable && s1_valid_reg && (s1_item_reg.command == CMD_CLEAR), hist_live_reg == '0)
    `ASSERT_NEXT(a_accept_enters_pipe, aclk, aresetn, accept, s1_valid_reg)

endmodule
